@@ rtl/usd_pkg.sv @@
// usd_pkg: types and constants shared by the utf-8 stream decoder
// no dependencies; compiled first
`default_nettype none

package usd_pkg;

   localparam int CP_WIDTH          = 21;
   localparam int RSP_DEPTH_DEFAULT = 4;

   // lead byte ranges
   localparam logic [7:0] ASCII_HI = 8'h7F;
   localparam logic [7:0] LEAD2_LO = 8'hC0;
   localparam logic [7:0] LEAD2_HI = 8'hDF;
   localparam logic [7:0] LEAD3_LO = 8'hE0;
   localparam logic [7:0] LEAD3_HI = 8'hEF;
   localparam logic [7:0] LEAD4_LO = 8'hF0;
   localparam logic [7:0] LEAD4_HI = 8'hF7;

   localparam logic [1:0] CONT_TAG = 2'b10;
   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_ONE = 2'd1;
   localparam logic [1:0] PEND_TWO = 2'd2;
   localparam logic [1:0] PEND_THREE = 2'd3;

   localparam logic [CP_WIDTH-1:0] REPLACEMENT = 21'h00FFFD;

   typedef struct packed {
      logic [CP_WIDTH-1:0] code_point;
      logic                run_last;
      logic                string_done;
   } result_type;

   // results produced by one accepted byte
   typedef struct packed {
      logic [1:0] beats;
      result_type first;
      result_type second;
   } push_type;

endpackage

`default_nettype wire

@@ rtl/usd_ifs.sv @@
// usd_req_if / usd_rsp_if: valid-ready channels of the utf-8 stream decoder
// no dependencies
`default_nettype none

interface usd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       string_end;

   modport source (output valid, output in_byte, output string_end, input ready);
   modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface usd_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic        run_last;
   logic        string_done;

   modport source (output valid, output code_point, output run_last,
                   output string_done, input ready);
   modport sink   (input valid, input code_point, input run_last,
                   input string_done, output ready);
endinterface

`default_nettype wire

@@ rtl/usd_decode.sv @@
// usd_decode: per-byte decode and partial code point state
// depends on usd_pkg
`default_nettype none

module usd_decode
   import usd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] in_byte,
   input  wire logic       string_end,
   output push_type        push
);

   logic [CP_WIDTH-1:0] partial_ff, partial_in;
   logic [1:0]          pending_ff, pending_in;

   always_comb begin
      logic                is_cont;
      logic [CP_WIDTH-1:0] shifted;
      logic [1:0]          pend_dec;
      logic                lead_emit;
      logic [CP_WIDTH-1:0] lead_cp;
      logic [CP_WIDTH-1:0] lead_val;
      logic [1:0]          lead_pend;
      logic                lead_has;
      result_type          lead_res;

      is_cont   = (in_byte[7:6] == CONT_TAG);
      shifted   = {partial_ff[CP_WIDTH-7:0], in_byte[5:0]};
      pend_dec  = pending_ff - 2'd1;
      lead_emit = 1'b0;
      lead_cp   = REPLACEMENT;
      lead_val  = '0;
      lead_pend = PEND_NONE;
      lead_has  = 1'b0;
      lead_res  = '0;
      push       = '0;
      partial_in = partial_ff;
      pending_in = pending_ff;

      case (in_byte) inside
         [8'h00:ASCII_HI]: begin
            lead_emit = 1'b1;
            lead_cp   = {13'd0, in_byte};
         end
         [LEAD2_LO:LEAD2_HI]: begin
            lead_val  = {16'd0, in_byte[4:0]};
            lead_pend = PEND_ONE;
         end
         [LEAD3_LO:LEAD3_HI]: begin
            lead_val  = {17'd0, in_byte[3:0]};
            lead_pend = PEND_TWO;
         end
         [LEAD4_LO:LEAD4_HI]: begin
            lead_val  = {18'd0, in_byte[2:0]};
            lead_pend = PEND_THREE;
         end
         default: begin
            lead_emit = 1'b1;
            lead_cp   = REPLACEMENT;
         end
      endcase

      if (pending_ff != PEND_NONE && is_cont) begin
         if (pend_dec == PEND_NONE || string_end) begin
            push.beats = 2'd1;
            push.first = '{code_point: shifted, run_last: 1'b1, string_done: string_end};
            partial_in = '0;
            pending_in = PEND_NONE;
         end else begin
            partial_in = shifted;
            pending_in = pend_dec;
         end
      end else begin
         if (lead_emit) begin
            lead_has   = 1'b1;
            lead_res   = '{code_point: lead_cp, run_last: 1'b1, string_done: string_end};
            partial_in = '0;
            pending_in = PEND_NONE;
         end else if (string_end) begin
            lead_has   = 1'b1;
            lead_res   = '{code_point: lead_val, run_last: 1'b1, string_done: 1'b1};
            partial_in = '0;
            pending_in = PEND_NONE;
         end else begin
            partial_in = lead_val;
            pending_in = lead_pend;
         end

         if (pending_ff != PEND_NONE) begin
            push.first  = '{code_point: REPLACEMENT, run_last: 1'b0, string_done: 1'b0};
            push.second = lead_res;
            push.beats  = lead_has ? 2'd2 : 2'd1;
         end else begin
            push.first = lead_res;
            push.beats = {1'b0, lead_has};
         end
      end

      if (!accept) begin
         push.beats = 2'd0;
         partial_in = partial_ff;
         pending_in = pending_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         pending_ff <= PEND_NONE;
      end else begin
         partial_ff <= partial_in;
         pending_ff <= pending_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/usd_rsp_fifo.sv @@
// usd_rsp_fifo: result queue taking up to two beats per cycle, one out
// depends on usd_pkg
`default_nettype none

module usd_rsp_fifo
   import usd_pkg::*;
#(
   parameter int DEPTH = RSP_DEPTH_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   input  wire logic     pop,
   output logic          room_for_two,
   output logic          head_valid,
   output result_type    head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

   result_type        slots_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [PW-1:0]     wr_next;
   logic              do_pop;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] ptr);
      return (ptr == LAST_SLOT) ? '0 : ptr + PW'(1);
   endfunction

   assign wr_next      = bump(wr_ptr_ff);
   assign do_pop       = pop && head_valid;
   assign head_valid   = (count_ff != '0);
   assign head         = slots_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= CW'(DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      case (push.beats)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = bump(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push.beats) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push.beats != 2'd0) begin
         slots_ff[wr_ptr_ff] <= push.first;
      end
      if (push.beats == 2'd2) begin
         slots_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/utf8_stream_decoder.sv @@
// utf8_stream_decoder: top level of the utf-8 byte stream decoder
// depends on usd_pkg, usd_ifs, usd_decode, usd_rsp_fifo
//
// usage:
//   req_bus carries one string byte per beat (in_byte) and string_end on
//   the last byte of a string. rsp_bus carries decoded code points, with
//   run_last on each result decoded from the byte itself (not on the
//   replacement for a cut-off sequence), string_done on the final result
//   of an ended string. a byte gives zero, one or two result beats. a
//   result is queued as its byte is accepted and offered on rsp_bus behind
//   earlier results. bytes go in one per cycle while each yields at most one
//   result and the receiver keeps up; the port drains one beat per cycle.
//   req_bus.ready is high while the result queue (RSP_DEPTH beats) has room
//   for two beats, independent of req_bus.valid.
//   reset clears the partial code point, the pending count and the queue.
//   when the receiver stalls, results wait in the queue and req_bus.ready
//   drops once fewer than two free slots remain; nothing is lost.
`default_nettype none

module utf8_stream_decoder
   import usd_pkg::*;
#(
   parameter int RSP_DEPTH = RSP_DEPTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   usd_req_if.sink    req_bus,
   usd_rsp_if.source  rsp_bus
);

   push_type   push;
   result_type head;
   logic       room_for_two;
   logic       head_valid;
   logic       accept;

   assign req_bus.ready = room_for_two;
   assign accept        = req_bus.valid && room_for_two;

   usd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_bus.in_byte),
      .string_end (req_bus.string_end),
      .push       (push)
   );

   usd_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .pop          (rsp_bus.ready),
      .room_for_two (room_for_two),
      .head_valid   (head_valid),
      .head         (head)
   );

   assign rsp_bus.valid       = head_valid;
   assign rsp_bus.code_point  = head.code_point;
   assign rsp_bus.run_last    = head.run_last;
   assign rsp_bus.string_done = head.string_done;

endmodule

`default_nettype wire
